// ----- rtl/rsa_pkg.sv -----
`timescale 1ns / 1ps

package rsa_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MODULUS     = 2'd0;
	localparam cfg_idx_t REG_PUBLIC_EXP  = 2'd1;
	localparam cfg_idx_t REG_PRIVATE_EXP = 2'd2;

	// Request codes.
	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	// Reset values of the key registers, before trimming to the modulus width.
	localparam logic [31:0] MODULUS_RST     = 32'd2;
	localparam logic [31:0] PUBLIC_EXP_RST  = 32'd65537;
	localparam logic [31:0] PRIVATE_EXP_RST = 32'd1;

	// Width of the character byte and of a decrypted result.
	localparam int BYTE_W = 8;

endpackage

// ----- rtl/rsa_modmul.sv -----
`timescale 1ns / 1ps

// Bit-serial interleaved modular multiplier: r = a * b mod n, with a < n.
// The multiplier b is scanned most significant bit first, one bit a cycle.
module rsa_modmul #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] n,
	output logic         done,
	output logic [W-1:0] r
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  b_q;

	logic [W+1:0] sum;
	logic [W+1:0] n1;
	logic [W+1:0] n2;
	logic [W+1:0] red;

	// The accumulator stays below n, so 2*acc + a stays below 3n and at most
	// one of n or 2n has to be taken off.
	always_comb begin
		n1  = {2'b00, n};
		n2  = {1'b0, n, 1'b0};
		sum = {1'b0, acc_q, 1'b0} + (b_q[W-1] ? {2'b00, a} : '0);
		if (sum >= n2) begin
			red = sum - n2;
		end else if (sum >= n1) begin
			red = sum - n1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= red[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign r    = acc_q;

endmodule

// ----- rtl/rsa_modexp_cipher_core.sv -----
`timescale 1ns / 1ps

// One request at a time: busy stays high until the result strobe, whose cycle
// already accepts the next start. Each exponent bit takes one pass of the two
// bit-serial multipliers. Asynchronous active-low reset returns the FSM to idle and the
// key registers to n = 2, public exponent 65537, private exponent 1; results cannot stall.
module rsa_modexp_cipher_core #(
	parameter int MOD_WIDTH = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    req_type,
	input  logic [MOD_WIDTH-1:0]    operand_value,
	output logic                    result_valid,
	output logic [MOD_WIDTH-1:0]    result_value,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  rsa_pkg::cfg_idx_t       cfg_index,
	input  logic [MOD_WIDTH-1:0]    cfg_data
);

	import rsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_REDUCE,
		S_ROUND,
		S_WAIT,
		S_DONE
	} state_t;

	localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);

	state_t                 state_q;
	logic                   req_q;
	logic [MOD_WIDTH-1:0]   exp_q;
	logic [MOD_WIDTH-1:0]   base_q;
	logic [MOD_WIDTH-1:0]   acc_q;
	logic                   result_valid_q;
	logic [MOD_WIDTH-1:0]   result_value_q;

	logic [MOD_WIDTH-1:0]   modulus_q;
	logic [MOD_WIDTH-1:0]   public_exp_q;
	logic [MOD_WIDTH-1:0]   private_exp_q;

	logic                   mul_start;
	logic                   reducing;
	logic [MOD_WIDTH-1:0]   sq_a;
	logic                   acc_done;
	logic                   sq_done;
	logic [MOD_WIDTH-1:0]   acc_prod;
	logic [MOD_WIDTH-1:0]   sq_prod;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= MOD_WIDTH'(MODULUS_RST);
			public_exp_q  <= MOD_WIDTH'(PUBLIC_EXP_RST);
			private_exp_q <= MOD_WIDTH'(PRIVATE_EXP_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS:     modulus_q     <= cfg_data;
				REG_PUBLIC_EXP:  public_exp_q  <= cfg_data;
				REG_PRIVATE_EXP: private_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The initial reduction of the operand is a multiplication by one.
	assign reducing  = (state_q == S_LOAD) || (state_q == S_REDUCE);
	assign mul_start = (state_q == S_LOAD) || ((state_q == S_ROUND) && (exp_q != '0));
	assign sq_a      = reducing ? ONE : base_q;

	rsa_modmul #(.W(MOD_WIDTH)) u_mul_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start && !reducing),
		.a      (acc_q),
		.b      (base_q),
		.n      (modulus_q),
		.done   (acc_done),
		.r      (acc_prod)
	);

	rsa_modmul #(.W(MOD_WIDTH)) u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sq_a),
		.b      (base_q),
		.n      (modulus_q),
		.done   (sq_done),
		.r      (sq_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (modulus_q < MOD_WIDTH'(2)) ? S_DONE : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					if (sq_done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= (exp_q == '0) ? S_DONE : S_WAIT;
				end
				S_WAIT: begin
					if (sq_done && acc_done) begin
						state_q <= S_ROUND;
					end
				end
				S_DONE: begin
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req_type;
					exp_q <= (req_type == REQ_DECRYPT) ? private_exp_q : public_exp_q;
					acc_q <= '0;
					if (req_type == REQ_DECRYPT) begin
						base_q <= operand_value;
					end else begin
						base_q <= {{(MOD_WIDTH-BYTE_W){1'b0}}, operand_value[BYTE_W-1:0]};
					end
				end
			end
			S_REDUCE: begin
				if (sq_done) begin
					base_q <= sq_prod;
					acc_q  <= ONE;
				end
			end
			S_WAIT: begin
				// Both multipliers run in lock step, so their done flags rise together.
				if (sq_done && acc_done) begin
					if (exp_q[0]) begin
						acc_q <= acc_prod;
					end
					base_q <= sq_prod;
					exp_q  <= exp_q >> 1;
				end
			end
			S_DONE: begin
				if (req_q == REQ_DECRYPT) begin
					result_value_q <= {{(MOD_WIDTH-BYTE_W){1'b0}}, acc_q[BYTE_W-1:0]};
				end else begin
					result_value_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result_value = result_value_q;

endmodule

// ----- rtl/rsa_core_checker.sv -----
`timescale 1ns / 1ps

module rsa_core_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid
);

	import rsa_pkg::*;

	// A result is only ever shown once the block has gone back to idle.
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// An accepted beat always starts work.
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted start did not raise busy");

	// Each request completes with exactly one strobe.
	a_fall_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy fell without a result");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

endmodule

bind rsa_modexp_cipher_core rsa_core_checker u_rsa_core_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid)
);
